### rtl/vbpd_pkg.sv
`default_nettype none
package vbpd_pkg;

  localparam int PALETTE_DEPTH       = 16;
  localparam int COLUMNS_PER_SEGMENT = 16;
  localparam int COL_W               = $clog2(COLUMNS_PER_SEGMENT);
  localparam int PAL_W               = $clog2(PALETTE_DEPTH);

  // visible window
  localparam logic [8:0] FIRST_LINE   = 9'd56;
  localparam logic [5:0] LAST_SEGMENT = 6'd41;

  typedef enum logic [2:0] {
    MODE_ATTR       = 3'd0,
    MODE_4C         = 3'd1,
    MODE_4C_SPECIAL = 3'd2,
    MODE_16C        = 3'd3,
    MODE_2C         = 3'd4
  } mode_t;

  typedef enum logic [0:0] {
    REG_VIDEO_MODE    = 1'b0,
    REG_BORDER_COLOUR = 1'b1
  } reg_index_t;

  // one classified request; data is {shape, colour} for a segment,
  // {entry, red, green, blue} for a palette write
  typedef struct packed {
    logic             is_write;
    logic             is_border;
    mode_t            mode;
    logic [PAL_W-1:0] border_colour;
    logic [15:0]      data;
  } queue_entry_t;

endpackage
`default_nettype wire

### rtl/video_byte_pair_pixel_decoder_core.sv
`default_nettype none
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_ready   op, line_number, segment_index, shape_byte,
//                                            colour_byte, palette_entry, *_level
// pixel     out        out_valid / out_ready pixel_index, red, green, blue, is_border, last
// config    in         APB psel/penable      paddr, pwdata, prdata (0: mode, 4: border)
//
// A segment request gives 16 pixels, one per clock while out_ready is high:
// the pixel channel carries one pixel per handshake.
// A palette write updates the palette in the back end and gives no pixel.
// Synchronous reset clears the palette, registers, queue and output valid.
// The queue lets the front accept requests while pixels are stalled downstream.
module video_byte_pair_pixel_decoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [8:0]  line_number,
  input  wire logic [5:0]  segment_index,
  input  wire logic [7:0]  shape_byte,
  input  wire logic [7:0]  colour_byte,
  input  wire logic [3:0]  palette_entry,
  input  wire logic [3:0]  red_level,
  input  wire logic [3:0]  green_level,
  input  wire logic [3:0]  blue_level,
  // pixel channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       pixel_index,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic             is_border,
  output logic             last,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import vbpd_pkg::*;

  logic [2:0]   video_mode;
  logic [3:0]   border_colour;
  logic         cfg_write;
  reg_index_t   reg_sel;

  logic         push_valid;
  logic         push_ready;
  queue_entry_t push_entry;
  logic         head_valid;
  queue_entry_t head_entry;
  logic         pop;

  // ---------------------------------------------------------------------------
  // Configuration registers: the user must write them only while the datapath is idle
  // (the block does not enforce this), so the front end may sample them as each request is classified.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      video_mode    <= 3'd0;
      border_colour <= 4'd0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_VIDEO_MODE:    video_mode    <= pwdata[2:0];
        REG_BORDER_COLOUR: border_colour <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_VIDEO_MODE:    prdata = {29'd0, video_mode};
      REG_BORDER_COLOUR: prdata = {28'd0, border_colour};
      default:           prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Front end: classify (border, mode) and pack the request for the queue.
  // ---------------------------------------------------------------------------
  vbpd_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .line_number   (line_number),
    .segment_index (segment_index),
    .shape_byte    (shape_byte),
    .colour_byte   (colour_byte),
    .palette_entry (palette_entry),
    .red_level     (red_level),
    .green_level   (green_level),
    .blue_level    (blue_level),
    .video_mode    (video_mode),
    .border_colour (border_colour),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_entry    (push_entry)
  );

  // Palette writes travel through the queue too, keeping them in order with
  // the segments around them.
  vbpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .head_valid (head_valid),
    .pop        (pop),
    .head_entry (head_entry)
  );

  // ---------------------------------------------------------------------------
  // Back end: column counter, palette, gamma tables and output register.
  // ---------------------------------------------------------------------------
  vbpd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_entry  (head_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_index (pixel_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .is_border   (is_border),
    .last        (last)
  );

endmodule
`default_nettype wire

### rtl/vbpd_front.sv
`default_nettype none
module vbpd_front (
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       op,
  input  wire logic [8:0]                 line_number,
  input  wire logic [5:0]                 segment_index,
  input  wire logic [7:0]                 shape_byte,
  input  wire logic [7:0]                 colour_byte,
  input  wire logic [3:0]                 palette_entry,
  input  wire logic [3:0]                 red_level,
  input  wire logic [3:0]                 green_level,
  input  wire logic [3:0]                 blue_level,
  input  wire logic [2:0]                 video_mode,
  input  wire logic [3:0]                 border_colour,
  output logic                            push_valid,
  input  wire logic                       push_ready,
  output vbpd_pkg::queue_entry_t          push_entry
);
  import vbpd_pkg::*;

  mode_t mode;

  // unused codes fall back to attribute mode
  always_comb begin
    case (video_mode)
      3'd1:    mode = MODE_4C;
      3'd2:    mode = MODE_4C_SPECIAL;
      3'd3:    mode = MODE_16C;
      3'd4:    mode = MODE_2C;
      default: mode = MODE_ATTR;
    endcase
  end

  always_comb begin
    push_entry.is_write      = op;
    push_entry.is_border     = (line_number < FIRST_LINE) || line_number[8] ||
                               (segment_index == 6'd0) ||
                               (segment_index >= LAST_SEGMENT);
    push_entry.mode          = mode;
    push_entry.border_colour = border_colour;
    push_entry.data          = op ? {palette_entry, red_level, green_level, blue_level}
                                  : {shape_byte, colour_byte};
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule
`default_nettype wire

### rtl/vbpd_queue.sv
`default_nettype none
module vbpd_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push_valid,
  output logic                       push_ready,
  input  wire vbpd_pkg::queue_entry_t push_entry,
  output logic                       head_valid,
  input  wire logic                  pop,
  output vbpd_pkg::queue_entry_t     head_entry
);
  import vbpd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  queue_entry_t     entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/vbpd_back.sv
`default_nettype none
module vbpd_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  head_valid,
  input  wire vbpd_pkg::queue_entry_t head_entry,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [3:0]                 pixel_index,
  output logic [7:0]                 red,
  output logic [7:0]                 green,
  output logic [7:0]                 blue,
  output logic                       is_border,
  output logic                       last
);
  import vbpd_pkg::*;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS_PER_SEGMENT - 1);

  // 2*(level_table-64)+16
  function automatic logic [7:0] gamma(input logic [3:0] level);
    logic [7:0] g;
    case (level)
      4'd0:    g = 8'd48;
      4'd1:    g = 8'd124;
      4'd2:    g = 8'd144;
      4'd3:    g = 8'd160;
      4'd4:    g = 8'd172;
      4'd5:    g = 8'd182;
      4'd6:    g = 8'd192;
      4'd7:    g = 8'd200;
      4'd8:    g = 8'd208;
      4'd9:    g = 8'd214;
      4'd10:   g = 8'd220;
      4'd11:   g = 8'd226;
      4'd12:   g = 8'd232;
      4'd13:   g = 8'd238;
      4'd14:   g = 8'd244;
      default: g = 8'd248;
    endcase
    return g;
  endfunction

  logic [11:0]      palette [PALETTE_DEPTH];
  logic [COL_W-1:0] col;
  logic             advance;
  logic             step;
  logic             do_write;
  logic [7:0]       shape;
  logic [7:0]       colour;
  logic [2:0]       bit_sel;
  logic [3:0]       back_idx;
  logic [3:0]       fore_idx;
  logic [3:0]       col_idx;
  logic [PAL_W-1:0] idx;
  logic [11:0]      entry;

  assign advance  = !out_valid || out_ready;
  assign step     = head_valid && !head_entry.is_write && advance;
  assign do_write = head_valid && head_entry.is_write;
  assign pop      = do_write || (step && (col == COL_LAST));

  assign shape    = head_entry.data[15:8];
  assign colour   = head_entry.data[7:0];
  assign bit_sel  = ~col[3:1];  // leftmost bit first, two columns per bit
  assign back_idx = {~colour[7], colour[2:0]};
  assign fore_idx = {~colour[6], colour[5:3]};

  always_comb begin
    case (head_entry.mode)
      MODE_4C:         col_idx = {2'b00, shape[bit_sel], colour[bit_sel]};
      MODE_4C_SPECIAL: col_idx = {2'b00, head_entry.data[{bit_sel, 1'b0} +: 2]};
      MODE_16C:        col_idx = head_entry.data[{~col[3:2], 2'b00} +: 4];
      MODE_2C:         col_idx = {3'b000, head_entry.data[~col]};
      default:         col_idx = shape[bit_sel] ? fore_idx : back_idx;
    endcase
  end

  assign idx   = head_entry.is_border ? head_entry.border_colour : col_idx;
  assign entry = palette[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
        palette[i] <= '0;
      end
    end else if (do_write) begin
      palette[head_entry.data[15:12]] <= head_entry.data[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        col <= col + 1'b1;
      end
      if (advance) begin
        out_valid <= step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pixel_index <= idx;
      red         <= gamma(entry[11:8]);
      green       <= gamma(entry[7:4]);
      blue        <= gamma(entry[3:0]);
      is_border   <= head_entry.is_border;
      last        <= (col == COL_LAST);
    end
  end

endmodule
`default_nettype wire

### bench/video_byte_pair_pixel_decoder_core_tb.sv
`default_nettype none
module video_byte_pair_pixel_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vbpd_pkg::*;

  // Lines after this one are border again
  localparam logic [8:0] LAST_LINE = 9'd255;
  // Mode codes the block does not define; they decode as the attribute mode
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  // After the last pixel a trailing palette write may still sit in the queue
  // or the back end; this covers the queue depth plus the back end, with margin.
  localparam int SETTLE_CYCLES   = 40;
  // Long downstream hold used to fill the queue and stall the request side
  localparam int HOLD_CYCLES     = 300;
  // Cycles without any handshake before the run is declared hung.  The worst
  // correct case is the long hold above plus a long sender gap.
  localparam int WATCHDOG_CYCLES = 3000;
  localparam int MAX_PRINTED     = 32;

  typedef struct {
    logic       op;
    logic [8:0] line;
    logic [5:0] seg;
    logic [7:0] shape;
    logic [7:0] colour;
    logic [3:0] entry;
    logic [3:0] r;
    logic [3:0] g;
    logic [3:0] b;
  } request_t;

  typedef struct {
    logic [3:0] index;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       border;
    logic       last;
  } pixel_t;

  logic        clk;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic        op            = 1'b0;
  logic [8:0]  line_number   = '0;
  logic [5:0]  segment_index = '0;
  logic [7:0]  shape_byte    = '0;
  logic [7:0]  colour_byte   = '0;
  logic [3:0]  palette_entry = '0;
  logic [3:0]  red_level     = '0;
  logic [3:0]  green_level   = '0;
  logic [3:0]  blue_level    = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [3:0]  pixel_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        is_border;
  logic        last;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  video_byte_pair_pixel_decoder_core dut (.*);

  // Own copy of the block's state and registers
  logic [11:0] palette_model [PALETTE_DEPTH];
  logic [2:0]  mode_model;
  logic [3:0]  border_model;
  int          level_curve [16] = '{80, 118, 128, 136, 142, 147, 152, 156,
                                    160, 163, 166, 169, 172, 175, 178, 180};

  pixel_t expected_pixels [$];
  int     error_count    = 0;
  int     pixels_checked = 0;
  bit     sender_gaps    = 1'b1;
  bit     hold_pixels    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_PRINTED)
      $display("[%0t] MISMATCH %s at pixel %0d: got %0d, want %0d",
               $realtime, what, pixels_checked, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // gamma curve: 2*(curve-64)+16
  function automatic logic [7:0] gamma_component(input logic [3:0] level);
    return 8'(2 * (level_curve[level] - 64) + 16);
  endfunction

  // palette index of one native column, leftmost column is 0
  function automatic logic [3:0] column_index(input logic [2:0] mode,
                                              input logic [7:0] shape,
                                              input logic [7:0] colour,
                                              input int col);
    logic [15:0] word;
    int          b;
    logic [3:0]  back;
    logic [3:0]  fore;
    word = {shape, colour};
    b    = 7 - col / 2;
    back = {~colour[7], colour[2:0]};
    fore = {~colour[6], colour[5:3]};
    case (mode)
      MODE_4C:         return {2'b00, shape[b], colour[b]};
      MODE_4C_SPECIAL: return {2'b00, word[15 - 2 * (col / 2) -: 2]};
      MODE_16C:        return word[15 - 4 * (col / 4) -: 4];
      MODE_2C:         return {3'b000, word[15 - col]};
      default:         return shape[b] ? fore : back;
    endcase
  endfunction

  // apply one accepted request to the model; a segment queues 16 pixels
  task automatic predict_request(input request_t q);
    logic       border;
    logic [3:0] idx;
    pixel_t     px;
    if (q.op) begin
      palette_model[q.entry] = {q.r, q.g, q.b};
    end else begin
      border = (q.line < FIRST_LINE) || (q.line > LAST_LINE) ||
               (q.seg == 6'd0) || (q.seg >= LAST_SEGMENT);
      for (int col = 0; col < COLUMNS_PER_SEGMENT; col++) begin
        idx       = border ? border_model : column_index(mode_model, q.shape, q.colour, col);
        px.index  = idx;
        px.r      = gamma_component(palette_model[idx][11:8]);
        px.g      = gamma_component(palette_model[idx][7:4]);
        px.b      = gamma_component(palette_model[idx][3:0]);
        px.border = border;
        px.last   = (col == COLUMNS_PER_SEGMENT - 1);
        expected_pixels.push_back(px);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request building
  // ---------------------------------------------------------------------------

  function automatic request_t make_decode(input logic [8:0] line, input logic [5:0] seg,
                                           input logic [7:0] shape, input logic [7:0] colour);
    request_t q;
    q = '{op: 1'b0, line: line, seg: seg, shape: shape, colour: colour,
          entry: 4'($urandom), r: 4'($urandom), g: 4'($urandom), b: 4'($urandom)};
    return q;
  endfunction

  // fields other than entry and levels are don't-care on a palette write
  function automatic request_t make_write(input logic [3:0] entry, input logic [3:0] r,
                                          input logic [3:0] g, input logic [3:0] b);
    request_t q;
    q = '{op: 1'b1, line: 9'($urandom), seg: 6'($urandom), shape: 8'($urandom),
          colour: 8'($urandom), entry: entry, r: r, g: g, b: b};
    return q;
  endfunction

  function automatic logic [7:0] random_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return 8'h00;
    if (pick < 20) return 8'hff;
    return 8'($urandom);
  endfunction

  // mostly visible segments, some border lines/segments, some palette writes
  function automatic request_t random_request();
    logic [8:0] line;
    logic [5:0] seg;
    int         pick;
    if ($urandom_range(0, 3) == 0)
      return make_write(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
    line = ($urandom_range(0, 99) < 80) ? 9'($urandom_range(56, 255))
                                        : 9'($urandom_range(0, 263));
    pick = $urandom_range(0, 99);
    if (pick < 85)
      seg = 6'($urandom_range(1, 40));
    else if (pick < 95)
      seg = $urandom_range(0, 1) ? LAST_SEGMENT : 6'd0;
    else
      seg = 6'($urandom_range(42, 63));
    return make_decode(line, seg, random_byte(), random_byte());
  endfunction

  // idle stretch length: mostly short, a few long
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 93) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers (all called right after a rising edge)
  // ---------------------------------------------------------------------------

  // offer one request, hold it until accepted, then maybe leave a gap
  task automatic send_request(input request_t q);
    int gap;
    in_valid      <= 1'b1;
    op            <= q.op;
    line_number   <= q.line;
    segment_index <= q.seg;
    shape_byte    <= q.shape;
    colour_byte   <= q.colour;
    palette_entry <= q.entry;
    red_level     <= q.r;
    green_level   <= q.g;
    blue_level    <= q.b;
    do @(posedge clk); while (!in_ready);
    predict_request(q);
    gap = (sender_gaps && $urandom_range(0, 1)) ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait until every pixel is out and the back end is quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one APB transfer: setup cycle, then access until pready
  task automatic apb_transfer(input reg_index_t idx, input bit wr,
                              input logic [31:0] data, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write a register, mirror it in the model and read it back
  task automatic write_register(input reg_index_t idx, input logic [31:0] value);
    logic [31:0] rdata;
    logic [31:0] want;
    apb_transfer(idx, 1'b1, value, rdata);
    if (idx == REG_VIDEO_MODE) begin
      mode_model = value[2:0];
      want       = {29'd0, value[2:0]};
    end else begin
      border_model = value[3:0];
      want         = {28'd0, value[3:0]};
    end
    apb_transfer(idx, 1'b0, '0, rdata);
    if (rdata !== want) report_mismatch("register readback", rdata, want);
  endtask

  // waits until the block is idle before writing the registers
  task automatic set_config(input logic [2:0] mode, input logic [3:0] border);
    wait_idle();
    write_register(REG_VIDEO_MODE, {29'd0, mode});
    write_register(REG_BORDER_COLOUR, {28'd0, border});
  endtask

  // ---------------------------------------------------------------------------
  // Pixel sink: random back-pressure, plus a long hold on request
  // ---------------------------------------------------------------------------
  initial begin : pixel_sink
    bit ready_now;
    int len;
    forever begin
      if (hold_pixels) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pixels = 1'b0;
      end else begin
        ready_now = ($urandom_range(0, 2) != 0);
        // ready runs are sometimes long, giving stretches with no stalls
        len = ready_now ? (($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                       : $urandom_range(1, 24))
                        : idle_length();
        out_ready <= ready_now;
        repeat (len) @(posedge clk);
      end
    end
  end

  // compare each accepted pixel with the oldest prediction
  always @(posedge clk) begin : pixel_checker
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected pixel, index", pixel_index, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_index !== want.index)  report_mismatch("pixel_index", pixel_index, want.index);
        if (red         !== want.r)      report_mismatch("red", red, want.r);
        if (green       !== want.g)      report_mismatch("green", green, want.g);
        if (blue        !== want.b)      report_mismatch("blue", blue, want.b);
        if (is_border   !== want.border) report_mismatch("is_border", is_border, want.border);
        if (last        !== want.last)   report_mismatch("last", last, want.last);
      end
      pixels_checked++;
    end
  end

  // hang detection: cycles with no handshake on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_CYCLES) begin
        $display("Watchdog: no request or pixel moved for %0d cycles", quiet);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset values: attribute mode, border 0, palette all zero
  task automatic test_reset_state();
    send_request(make_decode(9'd100, 6'd10, 8'hf0, 8'h00));
    send_request(make_decode(9'd100, 6'd0, 8'h5a, 8'h3c));
  endtask

  // attribute mode edges: foreground/background extremes, window limits
  task automatic test_attribute_edges();
    set_config(MODE_ATTR, 4'd15);
    send_request(make_write(4'd15, 4'd15, 4'd15, 4'd15));
    send_request(make_write(4'd0, 4'd0, 4'd0, 4'd0));
    send_request(make_write(4'd8, 4'd8, 4'd4, 4'd2));
    send_request(make_write(4'd7, 4'd1, 4'd2, 4'd3));
    send_request(make_decode(FIRST_LINE, 6'd1, 8'hff, 8'h00));   // all foreground
    send_request(make_decode(LAST_LINE, 6'd40, 8'h00, 8'hff));   // all background
    send_request(make_decode(9'd100, 6'd20, 8'ha5, 8'hc7));
    send_request(make_decode(9'd55, 6'd5, 8'ha5, 8'hc7));        // line just above window
    send_request(make_decode(9'd256, 6'd5, 8'ha5, 8'hc7));       // line just below window
    send_request(make_decode(9'd263, 6'd5, 8'hff, 8'hff));
    send_request(make_decode(9'd100, 6'd0, 8'hff, 8'hff));       // left border segment
    send_request(make_decode(9'd100, LAST_SEGMENT, 8'hff, 8'hff));
    send_request(make_decode(9'd100, 6'd42, 8'hff, 8'hff));      // beyond the line
    send_request(make_decode(9'd100, 6'd63, 8'h00, 8'h00));
  endtask

  // each defined mode with random traffic, border colour varied
  task automatic test_modes_random();
    logic [2:0] modes   [5] = '{MODE_ATTR, MODE_4C, MODE_4C_SPECIAL, MODE_16C, MODE_2C};
    logic [3:0] borders [5] = '{4'd0, 4'd15, 4'($urandom), 4'($urandom), 4'd15};
    for (int m = 0; m < 5; m++) begin
      set_config(modes[m], borders[m]);
      // one phase runs back to back on the request side
      sender_gaps = (modes[m] != MODE_16C);
      repeat (10) send_request(random_request());
    end
    sender_gaps = 1'b1;
  endtask

  // undefined mode codes fall back to attribute decoding
  task automatic test_unused_modes();
    set_config(MODE_UNUSED_LO, 4'($urandom));
    repeat (8) send_request(random_request());
    set_config(MODE_UNUSED_HI, 4'd0);
    repeat (8) send_request(random_request());
  endtask

  // hold the pixel side for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    set_config(MODE_4C_SPECIAL, 4'd9);
    sender_gaps = 1'b0;
    hold_pixels = 1'b1;
    for (int i = 0; i < 10; i++)
      send_request(make_decode(9'($urandom_range(56, 255)), 6'($urandom_range(1, 40)),
                               random_byte(), random_byte()));
    sender_gaps = 1'b1;
  endtask

  // palette rewrites separated by full drains, then read back through decodes
  task automatic test_drain_pause();
    set_config(MODE_16C, 4'd3);
    for (int i = 0; i < 3; i++) begin
      send_request(make_write(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom)));
      send_request(make_decode(9'($urandom_range(56, 255)), 6'($urandom_range(1, 40)),
                               8'h01, 8'h23));
      wait_idle();
      send_request(make_decode(9'($urandom_range(56, 255)), 6'($urandom_range(1, 40)),
                               8'h45, 8'h67));
    end
  endtask

  initial begin : stimulus
    for (int i = 0; i < PALETTE_DEPTH; i++) palette_model[i] = '0;
    mode_model   = MODE_ATTR;
    border_model = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_attribute_edges();
    test_modes_random();
    test_unused_modes();
    test_output_backpressure();
    test_drain_pause();

    wait_idle();
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
rtl/vbpd_pkg.sv
rtl/vbpd_front.sv
rtl/vbpd_queue.sv
rtl/vbpd_back.sv
rtl/video_byte_pair_pixel_decoder_core.sv
bench/video_byte_pair_pixel_decoder_core_tb.sv
